// File: src/rbst_pkg.sv
// Shared types and constants of the ray/box slab test.
`timescale 1ns / 1ps

package rbst_pkg;

	// Register indexes of the box corner registers
	typedef enum logic [2:0] {
		REG_BOX_MIN_X = 3'd0,
		REG_BOX_MIN_Y = 3'd1,
		REG_BOX_MIN_Z = 3'd2,
		REG_BOX_MAX_X = 3'd3,
		REG_BOX_MAX_Y = 3'd4,
		REG_BOX_MAX_Z = 3'd5
	} rbst_reg_t;

	localparam int NUM_REGS = 6;

	// Per-axis status that travels with a ray down the pipeline
	typedef struct packed {
		logic valid;
		logic parallel;
		logic in_slab;
	} rbst_axis_flags_t;

endpackage

// File: src/rbst_div.sv
// Pipelined saturating fixed-point divider, one quotient bit per stage.
`timescale 1ns / 1ps

module rbst_div #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W:0]   num,
	input  logic signed [W-1:0] den,
	output logic signed [W-1:0] quo
);
	localparam int XW  = 2 * W + F + 1;
	localparam int NIT = W - 1;

	logic [W:0]   a_abs;
	logic [W-1:0] b_abs;
	logic [W:0]   a_s1;
	logic [W-1:0] b_s1;
	logic         neg_s1;

	logic [XW-1:0]  rem_s [0:NIT];
	logic [XW-1:0]  dv_s  [0:NIT];
	logic [NIT-1:0] q_s   [0:NIT];
	logic           sat_s [0:NIT];
	logic           neg_s [0:NIT];

	logic [W-1:0] mag;

	assign a_abs = num[W] ? ((~$unsigned(num)) + {{W{1'b0}}, 1'b1}) : $unsigned(num);
	assign b_abs = den[W-1] ? ((~$unsigned(den)) + {{(W-1){1'b0}}, 1'b1}) : $unsigned(den);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= a_abs;
			b_s1   <= b_abs;
			neg_s1 <= num[W] ^ den[W-1];
		end
	end

	// Saturation check: quotient reaches 2^(W-1) when a*2^F >= b*2^(W-1)
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= XW'(a_s1) << F;
			dv_s[0]  <= XW'(b_s1);
			q_s[0]   <= '0;
			sat_s[0] <= (XW'(a_s1) << F) >= (XW'(b_s1) << (W - 1));
			neg_s[0] <= neg_s1;
		end
	end

	for (genvar j = 0; j < NIT; j++) begin : g_it
		localparam int K = NIT - 1 - j;
		logic [XW-1:0]  trial;
		logic           ge;
		logic [NIT-1:0] nq;

		always_comb begin
			trial = dv_s[j] << K;
			ge    = rem_s[j] >= trial;
			nq    = q_s[j];
			nq[K] = ge;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? (rem_s[j] - trial) : rem_s[j];
				dv_s[j+1]  <= dv_s[j];
				q_s[j+1]   <= nq;
				sat_s[j+1] <= sat_s[j];
				neg_s[j+1] <= neg_s[j];
			end
		end
	end

	assign mag = {1'b0, q_s[NIT]};

	always_ff @(posedge clk) begin
		if (en) begin
			if (sat_s[NIT]) begin
				quo <= neg_s[NIT] ? $signed({1'b1, {(W-1){1'b0}}})
				                  : $signed({1'b0, {(W-1){1'b1}}});
			end else begin
				quo <= neg_s[NIT] ? $signed(-mag) : $signed(mag);
			end
		end
	end

endmodule

// File: src/rbst_axis.sv
// One axis of the slab test: plane distances, two dividers, interval ordering.
`timescale 1ns / 1ps

module rbst_axis #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic signed [W-1:0]        pmin,
	input  logic signed [W-1:0]        pmax,
	input  logic signed [W-1:0]        org,
	input  logic signed [W-1:0]        dir,
	output rbst_pkg::rbst_axis_flags_t flags,
	output logic signed [W-1:0]        t_lo,
	output logic signed [W-1:0]        t_hi
);
	// divider stages: abs, saturation check, W-1 bit steps, output
	localparam int LAT = W + 2;

	logic signed [W:0]   num0_s1;
	logic signed [W:0]   num1_s1;
	logic signed [W-1:0] dir_s1;
	rbst_pkg::rbst_axis_flags_t fl_s1;
	rbst_pkg::rbst_axis_flags_t fl_sd [0:LAT-1];
	logic signed [W-1:0] t0;
	logic signed [W-1:0] t1;
	logic                between;

	assign between = ((org >= pmin) && (org <= pmax)) || ((org >= pmax) && (org <= pmin));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_s1 <= '0;
		end else if (en) begin
			fl_s1.valid    <= in_valid;
			fl_s1.parallel <= (dir == '0);
			fl_s1.in_slab  <= between;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num0_s1 <= {pmin[W-1], pmin} - {org[W-1], org};
			num1_s1 <= {pmax[W-1], pmax} - {org[W-1], org};
			dir_s1  <= dir;
		end
	end

	rbst_div #(.W(W), .F(F)) u_div0 (
		.clk (clk),
		.en  (en),
		.num (num0_s1),
		.den (dir_s1),
		.quo (t0)
	);

	rbst_div #(.W(W), .F(F)) u_div1 (
		.clk (clk),
		.en  (en),
		.num (num1_s1),
		.den (dir_s1),
		.quo (t1)
	);

	for (genvar i = 0; i < LAT; i++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fl_sd[i] <= '0;
			end else if (en) begin
				fl_sd[i] <= (i == 0) ? fl_s1 : fl_sd[(i == 0) ? 0 : i - 1];
			end
		end
	end

	// parallel axis gives the widest interval so it drops out of the merge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags <= '0;
		end else if (en) begin
			flags <= fl_sd[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (fl_sd[LAT-1].parallel) begin
				t_lo <= $signed({1'b1, {(W-1){1'b0}}});
				t_hi <= $signed({1'b0, {(W-1){1'b1}}});
			end else if (t0 > t1) begin
				t_lo <= t1;
				t_hi <= t0;
			end else begin
				t_lo <= t0;
				t_hi <= t1;
			end
		end
	end

endmodule

// File: src/ray_box_slab_test_top.sv
// Top level of the ray against axis-aligned box slab test.
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// ray       ray_valid/ray_stall    origin_x/y/z, dir_x/y/z
// result    res_valid/res_stall    hit
// config    APB (psel..pready)     box_min_x/y/z, box_max_x/y/z
//
// One ray per cycle enters while the result is not stalled; the path runs through the
// input register, COORD_WIDTH + 2 divider stages, ordering, merge and compare.
// The depth is set by the bit-per-stage restoring dividers, six of them.
// Reset clears the box registers to zero and all valid bits.
// A stalled result freezes the whole pipeline; ray_stall follows it.

module ray_box_slab_test_top #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16,
	localparam int DW = (COORD_WIDTH > 32) ? 64 : 32,
	localparam int AS = (COORD_WIDTH > 32) ? 3 : 2,
	localparam int AW = AS + 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [AW-1:0]                 paddr,
	input  logic [DW-1:0]                 pwdata,
	output logic [DW-1:0]                 prdata,
	output logic                          pready,
	// ray transfer
	input  logic                          ray_valid,
	output logic                          ray_stall,
	input  logic signed [COORD_WIDTH-1:0] origin_x,
	input  logic signed [COORD_WIDTH-1:0] origin_y,
	input  logic signed [COORD_WIDTH-1:0] origin_z,
	input  logic signed [COORD_WIDTH-1:0] dir_x,
	input  logic signed [COORD_WIDTH-1:0] dir_y,
	input  logic signed [COORD_WIDTH-1:0] dir_z,
	// result transfer
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic                          hit
);
	localparam int W = COORD_WIDTH;

	logic signed [W-1:0] box_min_x_q, box_min_y_q, box_min_z_q;
	logic signed [W-1:0] box_max_x_q, box_max_y_q, box_max_z_q;
	rbst_pkg::rbst_reg_t reg_idx;
	logic                idx_ok;
	logic                en;

	rbst_pkg::rbst_axis_flags_t fx, fy, fz;
	logic signed [W-1:0] lox, hix, loy, hiy, loz, hiz;
	logic signed [W-1:0] lo_xy, hi_xy, lo_max, hi_min;

	logic signed [W-1:0] lo_s3, hi_s3;
	logic                ok_s3, valid_s3;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = rbst_pkg::rbst_reg_t'(paddr[AW-1:AS]);
	assign idx_ok  = ({1'b0, paddr[AW-1:AS]} < 4'(rbst_pkg::NUM_REGS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_min_x_q <= '0;
			box_min_y_q <= '0;
			box_min_z_q <= '0;
			box_max_x_q <= '0;
			box_max_y_q <= '0;
			box_max_z_q <= '0;
		end else if (psel && penable && pwrite && idx_ok) begin
			unique case (reg_idx)
				rbst_pkg::REG_BOX_MIN_X: box_min_x_q <= $signed(pwdata[W-1:0]);
				rbst_pkg::REG_BOX_MIN_Y: box_min_y_q <= $signed(pwdata[W-1:0]);
				rbst_pkg::REG_BOX_MIN_Z: box_min_z_q <= $signed(pwdata[W-1:0]);
				rbst_pkg::REG_BOX_MAX_X: box_max_x_q <= $signed(pwdata[W-1:0]);
				rbst_pkg::REG_BOX_MAX_Y: box_max_y_q <= $signed(pwdata[W-1:0]);
				rbst_pkg::REG_BOX_MAX_Z: box_max_z_q <= $signed(pwdata[W-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (idx_ok) begin
			unique case (reg_idx)
				rbst_pkg::REG_BOX_MIN_X: prdata = DW'($unsigned(box_min_x_q));
				rbst_pkg::REG_BOX_MIN_Y: prdata = DW'($unsigned(box_min_y_q));
				rbst_pkg::REG_BOX_MIN_Z: prdata = DW'($unsigned(box_min_z_q));
				rbst_pkg::REG_BOX_MAX_X: prdata = DW'($unsigned(box_max_x_q));
				rbst_pkg::REG_BOX_MAX_Y: prdata = DW'($unsigned(box_max_y_q));
				rbst_pkg::REG_BOX_MAX_Z: prdata = DW'($unsigned(box_max_z_q));
				default:                 prdata = '0;
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	// every stage advances unless a finished result is held back
	assign en        = !(res_valid && res_stall);
	assign ray_stall = !en;

	// ---------------- per-axis slabs ----------------
	rbst_axis #(.W(W), .F(FRAC_BITS)) u_axis_x (
		.clk (clk), .arst_n (arst_n), .en (en), .in_valid (ray_valid),
		.pmin (box_min_x_q), .pmax (box_max_x_q), .org (origin_x), .dir (dir_x),
		.flags (fx), .t_lo (lox), .t_hi (hix)
	);

	rbst_axis #(.W(W), .F(FRAC_BITS)) u_axis_y (
		.clk (clk), .arst_n (arst_n), .en (en), .in_valid (ray_valid),
		.pmin (box_min_y_q), .pmax (box_max_y_q), .org (origin_y), .dir (dir_y),
		.flags (fy), .t_lo (loy), .t_hi (hiy)
	);

	rbst_axis #(.W(W), .F(FRAC_BITS)) u_axis_z (
		.clk (clk), .arst_n (arst_n), .en (en), .in_valid (ray_valid),
		.pmin (box_min_z_q), .pmax (box_max_z_q), .org (origin_z), .dir (dir_z),
		.flags (fz), .t_lo (loz), .t_hi (hiz)
	);

	// ---------------- interval merge ----------------
	// latest entry, earliest exit over the three axes
	assign lo_xy  = (lox > loy) ? lox : loy;
	assign lo_max = (lo_xy > loz) ? lo_xy : loz;
	assign hi_xy  = (hix < hiy) ? hix : hiy;
	assign hi_min = (hi_xy < hiz) ? hi_xy : hiz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= fx.valid;
		end
	end

	// a parallel axis outside its slab is a certain miss
	always_ff @(posedge clk) begin
		if (en) begin
			lo_s3 <= lo_max;
			hi_s3 <= hi_min;
			ok_s3 <= (!fx.parallel || fx.in_slab) && (!fy.parallel || fy.in_slab)
			      && (!fz.parallel || fz.in_slab);
		end
	end

	// output register; touching intervals count as a hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit <= ok_s3 && (lo_s3 <= hi_s3);
		end
	end

	// ---------------- assertions ----------------
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(hit))
		else $error("result changed while stalled");

	a_axes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		fx.valid == fy.valid && fy.valid == fz.valid)
		else $error("axis pipelines out of step");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s3) && $stable(lo_s3) && $stable(hi_s3))
		else $error("merge stage moved during stall");

endmodule

// File: tb/ray_box_hit_checker.sv
// Checker for the ray/box slab test: tracks the box registers, predicts hit, compares.
`timescale 1ns / 1ps

module ray_box_hit_checker #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16,
	parameter int AW          = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [AW-1:0]                 paddr,
	input  logic [31:0]                   pwdata,
	input  logic                          pready,
	input  logic                          ray_valid,
	input  logic                          ray_stall,
	input  logic signed [COORD_WIDTH-1:0] origin_x,
	input  logic signed [COORD_WIDTH-1:0] origin_y,
	input  logic signed [COORD_WIDTH-1:0] origin_z,
	input  logic signed [COORD_WIDTH-1:0] dir_x,
	input  logic signed [COORD_WIDTH-1:0] dir_y,
	input  logic signed [COORD_WIDTH-1:0] dir_z,
	input  logic                          res_valid,
	input  logic                          res_stall,
	input  logic                          hit,
	output int                            fail_count,
	output int                            pending
);
	localparam longint unsigned T_CAP = 64'd1 << (COORD_WIDTH - 1);

	logic signed [COORD_WIDTH-1:0] box_lo [3];
	logic signed [COORD_WIDTH-1:0] box_hi [3];
	bit hit_queue [$];

	// Saturating fixed-point quotient, magnitude truncated toward zero
	function automatic longint t_quot(longint num, longint den);
		longint unsigned a, b, q;
		bit neg;
		neg = (num < 0) != (den < 0);
		a = (num < 0) ? -num : num;
		b = (den < 0) ? -den : den;
		q = (a << FRAC_BITS) / b;
		if (q > T_CAP) q = T_CAP;
		if (neg) return -longint'(q);
		if (q > T_CAP - 1) q = T_CAP - 1;
		return longint'(q);
	endfunction

	function automatic bit line_hits_box(longint org [3], longint dir [3]);
		longint lo, hi, t0, t1, mn, mx, tmp;
		bit any;
		any = 0;
		lo = 0;
		hi = 0;
		for (int k = 0; k < 3; k++) begin
			mn = box_lo[k];
			mx = box_hi[k];
			if (dir[k] == 0) begin
				// parallel axis: origin must sit between the planes
				if (mn > mx) begin
					tmp = mn; mn = mx; mx = tmp;
				end
				if (org[k] < mn || org[k] > mx) return 0;
			end else begin
				t0 = t_quot(mn - org[k], dir[k]);
				t1 = t_quot(mx - org[k], dir[k]);
				if (t0 > t1) begin
					tmp = t0; t0 = t1; t1 = tmp;
				end
				if (!any) begin
					lo = t0; hi = t1; any = 1;
				end else begin
					if (t0 > lo) lo = t0;
					if (t1 < hi) hi = t1;
				end
				if (lo > hi) return 0;
			end
		end
		return 1;
	endfunction

	assign pending = hit_queue.size();

	always @(posedge clk or negedge arst_n) begin
		longint org [3];
		longint dir [3];
		bit want;
		int idx;
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				box_lo[k] <= '0;
				box_hi[k] <= '0;
			end
			hit_queue.delete();
			fail_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				idx = paddr >> 2;
				unique case (idx)
					rbst_pkg::REG_BOX_MIN_X: box_lo[0] <= pwdata[COORD_WIDTH-1:0];
					rbst_pkg::REG_BOX_MIN_Y: box_lo[1] <= pwdata[COORD_WIDTH-1:0];
					rbst_pkg::REG_BOX_MIN_Z: box_lo[2] <= pwdata[COORD_WIDTH-1:0];
					rbst_pkg::REG_BOX_MAX_X: box_hi[0] <= pwdata[COORD_WIDTH-1:0];
					rbst_pkg::REG_BOX_MAX_Y: box_hi[1] <= pwdata[COORD_WIDTH-1:0];
					rbst_pkg::REG_BOX_MAX_Z: box_hi[2] <= pwdata[COORD_WIDTH-1:0];
					default: ;
				endcase
			end
			if (ray_valid && !ray_stall) begin
				org[0] = origin_x; org[1] = origin_y; org[2] = origin_z;
				dir[0] = dir_x;    dir[1] = dir_y;    dir[2] = dir_z;
				hit_queue.push_back(line_hits_box(org, dir));
			end
			if (res_valid && !res_stall) begin
				if (hit_queue.size() == 0) begin
					$error("hit: result with nothing expected, actual %0b", hit);
					fail_count <= fail_count + 1;
				end else begin
					want = hit_queue.pop_front();
					if (hit !== want) begin
						$error("hit mismatch: expected %0b, actual %0b", want, hit);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// File: tb/tb.sv
// Testbench top for the ray/box slab test: stimulus, box setup and verdict.
`timescale 1ns / 1ps

module tb;
	localparam int CW        = 32;
	localparam int FB        = 16;
	localparam int AW        = 5;
	localparam int LATENCY   = CW + 6;
	localparam int MAX_CYC   = 400000;
	localparam int LONG_HOLD = 300;
	localparam longint CMIN  = -(64'sd1 <<< (CW - 1));
	localparam longint CMAX  = (64'sd1 <<< (CW - 1)) - 1;
	localparam longint ONE   = 64'sd1 <<< FB;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic ray_valid = 0;
	logic ray_stall;
	logic signed [CW-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [CW-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic res_valid;
	logic res_stall = 0;
	logic hit;

	int fail_count, pending;
	longint cyc = 0;

	// Traffic shaping shared by sender and receiver
	bit calm = 0;         // no idling on either side
	bit hold_req = 0;     // toggle to start a long result hold-off
	bit hold_seen = 0;
	int hold_left = 0;
	int res_wait = 0;

	// Box currently programmed, kept here to aim rays at it
	longint cur_lo [3];
	longint cur_hi [3];

	ray_box_slab_test_top #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (.*);

	ray_box_hit_checker #(.COORD_WIDTH(CW), .FRAC_BITS(FB), .AW(AW)) chk (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.ray_valid, .ray_stall, .origin_x, .origin_y, .origin_z,
		.dir_x, .dir_y, .dir_z, .res_valid, .res_stall, .hit,
		.fail_count, .pending
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// Watchdog: a hung pipeline ends the run
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > MAX_CYC) begin
			$display("FAIL");
			$finish;
		end
	end

	// Result side: random stall after each transfer, plus one long hold-off
	// that lets the pipeline fill up and push back on the ray channel.
	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 0;
		end else if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = LONG_HOLD;
			res_stall <= 1;
		end else if (hold_left > 0) begin
			hold_left--;
			res_stall <= (hold_left != 0);
		end else if (res_valid && !res_stall) begin
			res_wait = calm ? 0 : $urandom_range(0, 3);
			res_stall <= (res_wait != 0);
		end else if (res_wait > 0) begin
			res_wait--;
			res_stall <= (res_wait != 0);
		end
	end

	function automatic longint clamp(longint v);
		if (v < CMIN) return CMIN;
		if (v > CMAX) return CMAX;
		return v;
	endfunction

	function automatic longint rnd_coord();
		return longint'($signed($urandom()));
	endfunction

	// Values that sit on corners of the arithmetic
	function automatic longint edge_val();
		case ($urandom_range(0, 9))
			0: return CMIN;
			1: return CMAX;
			2: return 0;
			3: return 1;
			4: return -1;
			5: return ONE;
			6: return -ONE;
			7: return CMIN + 1;
			8: return longint'($urandom_range(0, 15)) - 8;
			default: return rnd_coord();
		endcase
	endfunction

	task automatic cfg_write(int idx, longint val);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= AW'(idx << 2);
		pwdata <= val[31:0];
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic set_box(longint lx, longint ly, longint lz,
			longint hx, longint hy, longint hz);
		cfg_write(rbst_pkg::REG_BOX_MIN_X, lx);
		cfg_write(rbst_pkg::REG_BOX_MIN_Y, ly);
		cfg_write(rbst_pkg::REG_BOX_MIN_Z, lz);
		cfg_write(rbst_pkg::REG_BOX_MAX_X, hx);
		cfg_write(rbst_pkg::REG_BOX_MAX_Y, hy);
		cfg_write(rbst_pkg::REG_BOX_MAX_Z, hz);
		cur_lo[0] = lx; cur_lo[1] = ly; cur_lo[2] = lz;
		cur_hi[0] = hx; cur_hi[1] = hy; cur_hi[2] = hz;
	endtask

	// One ray transfer: optional idle gap, then hold until accepted
	task automatic send_ray(longint ox, longint oy, longint oz,
			longint dx, longint dy, longint dz);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			ray_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		ray_valid <= 1;
		origin_x <= ox[CW-1:0];
		origin_y <= oy[CW-1:0];
		origin_z <= oz[CW-1:0];
		dir_x <= dx[CW-1:0];
		dir_y <= dy[CW-1:0];
		dir_z <= dz[CW-1:0];
		do @(posedge clk); while (ray_stall);
	endtask

	// Drain the pipeline before touching the box registers
	task automatic go_idle();
		ray_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic random_ray();
		longint o [3];
		longint d [3];
		longint tgt, span;
		int mode;
		mode = $urandom_range(0, 99);
		for (int k = 0; k < 3; k++) begin
			if (mode < 60) begin
				// aimed at (or just past) the box, random origin around it
				span = cur_hi[k] - cur_lo[k];
				if (span < 0) span = -span;
				tgt = (cur_lo[k] < cur_hi[k] ? cur_lo[k] : cur_hi[k])
					+ longint'($urandom_range(0, 1000)) * span / 900;
				o[k] = clamp(tgt + rnd_coord() / (1 << $urandom_range(4, 16)));
				d[k] = ($urandom_range(0, 9) == 0) ? 0 : clamp(tgt - o[k]);
				if ($urandom_range(0, 3) == 0) d[k] = -d[k];
				d[k] = clamp(d[k]);
			end else if (mode < 80) begin
				o[k] = rnd_coord();
				d[k] = rnd_coord();
			end else begin
				o[k] = edge_val();
				d[k] = ($urandom_range(0, 2) == 0) ? 0 : edge_val();
			end
		end
		send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
	endtask

	task automatic random_box(int shift);
		longint c [6];
		for (int k = 0; k < 6; k++) c[k] = rnd_coord() >>> shift;
		// mostly well ordered, sometimes inverted on an axis
		for (int k = 0; k < 3; k++)
			if (c[k] > c[k+3] && $urandom_range(0, 3) != 0) begin
				longint t;
				t = c[k]; c[k] = c[k+3]; c[k+3] = t;
			end
		set_box(c[0], c[1], c[2], c[3], c[4], c[5]);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Reset box is a single point at the origin
		for (int k = 0; k < 3; k++) begin
			cur_lo[k] = 0;
			cur_hi[k] = 0;
		end
		send_ray(0, 0, 0, 0, 0, 0);
		send_ray(-ONE, 0, 0, ONE, 0, 0);
		send_ray(1, 0, 0, 0, 0, 0);
		go_idle();

		// Unit box [-1, 1]^3: directed corner cases
		set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
		send_ray(0, 0, 0, 0, 0, 0);                       // all parallel, inside
		send_ray(2*ONE, 0, 0, 0, 0, 0);                   // all parallel, outside
		send_ray(ONE, ONE, ONE, 0, 0, 0);                 // parallel on the planes
		send_ray(-5*ONE, 0, 0, ONE, 0, 0);                // straight through
		send_ray(5*ONE, 0, 0, ONE, 0, 0);                 // box behind origin
		send_ray(-5*ONE, ONE, 0, ONE, 0, 0);              // grazing a face
		send_ray(-5*ONE, ONE + 1, 0, ONE, 0, 0);          // just missing
		send_ray(-3*ONE, -3*ONE, 0, ONE, ONE, 0);         // diagonal
		send_ray(-3*ONE, -ONE, 0, ONE, ONE, 0);           // touching corner
		send_ray(-3*ONE, 0, 0, ONE, 2*ONE, 0);            // skew miss
		send_ray(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);     // field extremes
		send_ray(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
		send_ray(CMIN, 0, 0, 1, 0, 0);                    // tiny divisor, saturates
		send_ray(CMAX, 0, 0, -1, 0, 0);
		send_ray(0, 0, 0, CMIN, 1, -1);
		send_ray(-1, -1, -1, -1, -1, -1);
		send_ray(ONE, -ONE, 0, -ONE, ONE, 1);
		go_idle();

		// Writes to unused register slots must not disturb the box
		cfg_write(rbst_pkg::NUM_REGS, CMAX);
		cfg_write(rbst_pkg::NUM_REGS + 1, CMIN);
		send_ray(0, 0, 0, 0, 0, 0);
		go_idle();

		// Widest box, then an inverted one
		set_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
		for (int i = 0; i < 150; i++) random_ray();
		go_idle();
		set_box(ONE, 2*ONE, CMAX, -ONE, -2*ONE, CMIN);
		for (int i = 0; i < 150; i++) random_ray();
		go_idle();

		// Random boxes of various scales; one phase with no idling and one
		// with a long result hold-off while rays keep coming.
		for (int ph = 0; ph < 7; ph++) begin
			random_box((ph == 6) ? 0 : $urandom_range(4, 14));
			calm = (ph == 2);
			if (ph == 4) hold_req = !hold_req;
			for (int i = 0; i < 150; i++) random_ray();
			calm = 0;
			go_idle();
		end

		ray_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
